>>> rtl/ntc_pkg.sv
// Package for the NTC thermistor converter: widths, constants, codes and tags.
// No dependencies; every other file imports it.
package ntc_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int ADC_W       = 16;
  localparam logic [ADC_W-1:0] FULL_SCALE = ADC_W'((32'd1 << SAMPLE_BITS) - 32'd1);

  localparam int TEMP_W      = 17;
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 20;
  localparam int BETA_W      = 16;
  localparam int OHM_W       = 20;
  localparam int T0_W        = 15;

  localparam logic [BETA_W-1:0] BETA_RST   = BETA_W'(3950);
  localparam logic [OHM_W-1:0]  SERIES_RST = OHM_W'(10000);
  localparam logic [OHM_W-1:0]  NOMINAL_RST = OHM_W'(10000);
  localparam logic [T0_W-1:0]   T0_RST     = T0_W'(2500);

  localparam int ZERO_K_CENTI = 27315;
  localparam int OUT_MAX      = 65535;

  // log unit
  localparam int X_W       = 20;
  localparam int M_W       = 31;
  localparam int E_W       = 5;
  localparam int FRAC_BITS = 28;
  localparam int LN2_W     = 28;
  localparam logic [LN2_W-1:0] LN2_Q28 = LN2_W'(186065280);
  localparam int LN_W      = 32;
  localparam int LOG_LAT   = FRAC_BITS + 3;

  // back end
  localparam int LNR_W  = 35;
  localparam int K0_W   = 16;
  localparam int PROD_W = LNR_W + K0_W + 1;
  localparam int DEN_W  = 54;
  localparam int D_W    = 53;
  localparam int P_W    = 40;
  localparam int Q_W    = FRAC_BITS;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_RAIL = 2'd1,
    ST_SAT  = 2'd2
  } conv_status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BETA    = 8'd0,
    REG_SERIES  = 8'd1,
    REG_NOMINAL = 8'd2,
    REG_T0      = 8'd3
  } cfg_reg_t;

  typedef struct packed {
    logic v;
    logic rail;
  } tag_t;

  typedef struct packed {
    logic v;
    logic rail;
    logic sat;
  } dtag_t;

endpackage

>>> rtl/ntc_sample_if.sv
// Sample channel: valid/ready plus one converter reading.
// Depends on ntc_pkg.
interface ntc_sample_if import ntc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ADC_W-1:0] adc_sample;
  modport source (output valid, output adc_sample, input ready);
  modport sink   (input valid, input adc_sample, output ready);
endinterface

>>> rtl/ntc_result_if.sv
// Result channel: valid/ready plus temperature and status.
// Depends on ntc_pkg.
interface ntc_result_if import ntc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [TEMP_W-1:0] temp_centi_c;
  conv_status_t             conv_status;
  modport source (output valid, output temp_centi_c, output conv_status, input ready);
  modport sink   (input valid, input temp_centi_c, input conv_status, output ready);
endinterface

>>> rtl/ntc_cfg_if.sv
// Configuration write channel: valid/ready, register index and write data.
// Depends on ntc_pkg.
interface ntc_cfg_if import ntc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/ntc_ln_lane.sv
// Pipelined natural log, Q28: normalize, 28 squaring steps, ln2 scale, round.
// Depends on ntc_pkg. All registers advance only on en.
module ntc_ln_lane import ntc_pkg::*; (
  input  logic            clk,
  input  logic            en,
  input  logic [X_W-1:0]  x,
  output logic [LN_W-1:0] ln
);

  localparam int LP_W = E_W + FRAC_BITS + LN2_W;

  logic [E_W-1:0]       e_nxt;
  logic [2*M_W-1:0]     xs;
  logic [M_W-1:0]       m_nxt;
  logic [M_W-1:0]       m_r [0:FRAC_BITS-1];
  logic [E_W-1:0]       e_r [0:FRAC_BITS];
  logic [FRAC_BITS-1:0] f_r [0:FRAC_BITS];
  logic [LP_W-1:0]      lp_r;
  logic [LP_W-1:0]      rnd;
  logic [LN_W-1:0]      ln_r;

  // leading one and normalize to [2^30, 2^31)
  always_comb begin
    e_nxt = '0;
    for (int i = 0; i < X_W; i++) begin
      if (x[i]) e_nxt = E_W'(i);
    end
    xs    = {{(2*M_W-X_W){1'b0}}, x} << (E_W'(M_W-1) - e_nxt);
    m_nxt = xs[M_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_r[0] <= m_nxt;
      e_r[0] <= e_nxt;
      f_r[0] <= '0;
    end
  end

  for (genvar g = 0; g < FRAC_BITS; g++) begin : g_sq
    logic [2*M_W-1:0]     sq;
    logic [M_W:0]         t;
    logic [FRAC_BITS-1:0] fb;

    always_comb begin
      sq = {{M_W{1'b0}}, m_r[g]} * {{M_W{1'b0}}, m_r[g]};
      t  = sq[2*M_W-1:M_W-1];
      fb = f_r[g];
      if (t[M_W]) fb[FRAC_BITS-1-g] = 1'b1;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        e_r[g+1] <= e_r[g];
        f_r[g+1] <= fb;
      end
    end

    if (g < FRAC_BITS-1) begin : g_m
      always_ff @(posedge clk) begin
        if (en) m_r[g+1] <= t[M_W] ? t[M_W:1] : t[M_W-1:0];
      end
    end else begin : g_last
      // last step only needs the fraction bit
    end
  end

  assign rnd = lp_r + (LP_W'(1) << (FRAC_BITS-1));

  always_ff @(posedge clk) begin
    if (en) begin
      lp_r <= LP_W'({e_r[FRAC_BITS], f_r[FRAC_BITS]}) * LP_W'(LN2_Q28);
      ln_r <= rnd[FRAC_BITS +: LN_W];
    end
  end

  assign ln = ln_r;

endmodule

>>> rtl/ntc_div_pipe.sv
// Pipelined restoring divider: range check, 28 quotient bits, round half up.
// Depends on ntc_pkg. All registers advance only on en.
module ntc_div_pipe import ntc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  tag_t                    tag_in,
  input  logic signed [DEN_W-1:0] den,
  input  logic [P_W-1:0]          p,
  output dtag_t                   tag_out,
  output logic [Q_W:0]            q_out
);

  logic [D_W-1:0] r_r [0:FRAC_BITS];
  logic [D_W-1:0] d_r [0:FRAC_BITS];
  logic [Q_W-1:0] q_r [0:FRAC_BITS];
  dtag_t          t_r [0:FRAC_BITS];
  dtag_t          to_r;
  logic [Q_W:0]   qo_r;
  logic           sat;
  logic [D_W:0]   r2_fin;

  // saturate when 1/T <= 0 or the quotient would reach one (p >= den)
  assign sat = (den <= 0) || (DEN_W'(p) >= $unsigned(den));

  always_ff @(posedge clk) begin
    if (en) begin
      r_r[0] <= D_W'(p);
      d_r[0] <= den[D_W-1:0];
      q_r[0] <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_r[0] <= '0;
    end else if (en) begin
      t_r[0] <= '{v: tag_in.v, rail: tag_in.rail, sat: sat};
    end
  end

  for (genvar g = 0; g < FRAC_BITS; g++) begin : g_step
    logic [D_W:0]   r2;
    logic           ge;
    logic [D_W:0]   rn;

    always_comb begin
      r2 = {r_r[g], 1'b0};
      ge = r2 >= {1'b0, d_r[g]};
      rn = ge ? (r2 - {1'b0, d_r[g]}) : r2;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        r_r[g+1] <= rn[D_W-1:0];
        d_r[g+1] <= d_r[g];
        q_r[g+1] <= {q_r[g][Q_W-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        t_r[g+1] <= '0;
      end else if (en) begin
        t_r[g+1] <= t_r[g];
      end
    end
  end

  assign r2_fin = {r_r[FRAC_BITS], 1'b0};

  always_ff @(posedge clk) begin
    if (en) begin
      qo_r <= {1'b0, q_r[FRAC_BITS]} +
              ((r2_fin >= {1'b0, d_r[FRAC_BITS]}) ? (Q_W+1)'(1) : (Q_W+1)'(0));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      to_r <= '0;
    end else if (en) begin
      to_r <= t_r[FRAC_BITS];
    end
  end

  assign tag_out = to_r;
  assign q_out   = qo_r;

endmodule

>>> rtl/ntc_thermistor_to_celsius.sv
// Top level of the NTC thermistor to Celsius converter (Beta equation).
// Depends on ntc_pkg, the three channel interfaces, ntc_ln_lane, ntc_div_pipe.
//
// Usage:
//  - in_bus carries one 16-bit divider sample per beat; out_bus returns one
//    beat per sample: temperature in 0.01 degC and a status code.
//  - cfg_bus writes beta, series ohms, nominal ohms and nominal temperature
//    (index 0..3, other indexes ignored). It is always ready; write only
//    while no sample is in flight.
//  - Path from input beat to result valid: the input stage, the log units,
//    the sum/multiply/denominator stages, the divider and the output register.
//    The 28-step squaring chain of the log and the 28-step divider set the
//    depth of that path.
//  - One sample per cycle while the skid is empty; all stages advance together.
//  - A stalled receiver fills a one-beat skid register behind the output
//    register; ready to the source then drops (registered) and the whole
//    pipe holds, nothing lost or repeated.
//  - Synchronous active-low reset clears all valid bits and loads the
//    register defaults; no clearing pass is needed.
module ntc_thermistor_to_celsius import ntc_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  ntc_sample_if.sink   in_bus,
  ntc_result_if.source out_bus,
  ntc_cfg_if.sink      cfg_bus
);

  // ---------------- configuration registers ----------------
  logic [BETA_W-1:0] beta_r;
  logic [OHM_W-1:0]  series_r;
  logic [OHM_W-1:0]  nominal_r;
  logic [T0_W-1:0]   t0_r;

  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beta_r    <= BETA_RST;
      series_r  <= SERIES_RST;
      nominal_r <= NOMINAL_RST;
      t0_r      <= T0_RST;
    end else if (cfg_bus.valid) begin
      unique case (cfg_reg_t'(cfg_bus.index))
        REG_BETA:    beta_r    <= cfg_bus.data[BETA_W-1:0];
        REG_SERIES:  series_r  <= cfg_bus.data[OHM_W-1:0];
        REG_NOMINAL: nominal_r <= cfg_bus.data[OHM_W-1:0];
        REG_T0:      t0_r      <= cfg_bus.data[T0_W-1:0];
        default: ;
      endcase
    end
  end

  // zero beta, series and nominal settings behave as one
  logic [BETA_W-1:0] b_eff;
  logic [OHM_W-1:0]  rs_eff;
  logic [OHM_W-1:0]  r0_eff;
  logic [K0_W:0]     k0_sum;
  logic [K0_W-1:0]   k0;

  assign b_eff  = (beta_r == '0)    ? BETA_W'(1) : beta_r;
  assign rs_eff = (series_r == '0)  ? OHM_W'(1)  : series_r;
  assign r0_eff = (nominal_r == '0) ? OHM_W'(1)  : nominal_r;
  // T0 in centikelvin; always positive and below 2^16
  assign k0_sum = {{(K0_W+1-T0_W){t0_r[T0_W-1]}}, t0_r} + (K0_W+1)'(ZERO_K_CENTI);
  assign k0     = k0_sum[K0_W-1:0];

  // ---------------- pipeline enable and skid ----------------
  logic en;
  logic sk_v_r;

  assign en           = ~sk_v_r;
  assign in_bus.ready = en;

  // ---------------- input stage ----------------
  logic [ADC_W-1:0] s_in;
  logic [ADC_W-1:0] s_r;
  tag_t             tag0_r;

  assign s_in = in_bus.adc_sample & FULL_SCALE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag0_r <= '0;
    end else if (en) begin
      tag0_r.v    <= in_bus.valid;
      tag0_r.rail <= (s_in == '0) || (s_in == FULL_SCALE);
    end
  end

  always_ff @(posedge clk) begin
    if (en) s_r <= s_in;
  end

  // ---------------- four log units ----------------
  logic [LN_W-1:0] ln_rs, ln_hi, ln_lo, ln_r0;
  logic [X_W-1:0]  x_hi, x_lo;

  assign x_hi = X_W'(FULL_SCALE - s_r);
  assign x_lo = X_W'(s_r);

  ntc_ln_lane u_ln_rs (.clk(clk), .en(en), .x(rs_eff), .ln(ln_rs));
  ntc_ln_lane u_ln_hi (.clk(clk), .en(en), .x(x_hi),   .ln(ln_hi));
  ntc_ln_lane u_ln_lo (.clk(clk), .en(en), .x(x_lo),   .ln(ln_lo));
  ntc_ln_lane u_ln_r0 (.clk(clk), .en(en), .x(r0_eff), .ln(ln_r0));

  tag_t ltag_r [0:LOG_LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LOG_LAT; i++) ltag_r[i] <= '0;
    end else if (en) begin
      ltag_r[0] <= tag0_r;
      for (int i = 1; i < LOG_LAT; i++) ltag_r[i] <= ltag_r[i-1];
    end
  end

  // ---------------- ln(R/R0), products, denominator ----------------
  logic signed [LNR_W-1:0]  lnr_r;
  logic signed [PROD_W-1:0] prod_r;
  logic [2*K0_W-1:0]        bk_r;
  logic signed [DEN_W-1:0]  den_r;
  logic [P_W-1:0]           p_r;
  logic [22:0]              b100;
  tag_t                     stag_r, mtag_r, dtag_r;

  assign b100 = {7'b0, b_eff} * 23'd100;

  always_ff @(posedge clk) begin
    if (en) begin
      lnr_r  <= $signed(LNR_W'(ln_rs) + LNR_W'(ln_hi) - LNR_W'(ln_lo) - LNR_W'(ln_r0));
      prod_r <= lnr_r * $signed({1'b0, k0});
      bk_r   <= (2*K0_W)'(b_eff) * (2*K0_W)'(k0);
      // 1/T scaled: ln_ratio*K0 + 100*B in Q28; numerator 100*B*K0
      den_r  <= DEN_W'(prod_r) + $signed(DEN_W'(b100) << FRAC_BITS);
      p_r    <= P_W'(bk_r) * P_W'(100);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stag_r <= '0;
      mtag_r <= '0;
      dtag_r <= '0;
    end else if (en) begin
      stag_r <= ltag_r[LOG_LAT-1];
      mtag_r <= stag_r;
      dtag_r <= mtag_r;
    end
  end

  // ---------------- divider ----------------
  dtag_t        qtag;
  logic [Q_W:0] q;

  ntc_div_pipe u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .tag_in  (dtag_r),
    .den     (den_r),
    .p       (p_r),
    .tag_out (qtag),
    .q_out   (q)
  );

  // ---------------- final select ----------------
  logic signed [Q_W+1:0]    res;
  logic signed [TEMP_W-1:0] fin_temp;
  conv_status_t             fin_st;

  assign res = $signed({1'b0, q}) - $signed((Q_W+2)'(ZERO_K_CENTI));

  always_comb begin
    if (qtag.rail) begin
      fin_temp = -TEMP_W'(ZERO_K_CENTI);
      fin_st   = ST_RAIL;
    end else if (qtag.sat || (res > $signed((Q_W+2)'(OUT_MAX)))) begin
      fin_temp = TEMP_W'(OUT_MAX);
      fin_st   = ST_SAT;
    end else begin
      fin_temp = res[TEMP_W-1:0];
      fin_st   = ST_OK;
    end
  end

  // ---------------- output register and skid ----------------
  logic                     out_v_r;
  logic signed [TEMP_W-1:0] out_temp_r, sk_temp_r;
  conv_status_t             out_st_r, sk_st_r;
  logic                     push;
  logic                     slot_free;

  assign push      = en & qtag.v;
  assign slot_free = ~out_v_r | out_bus.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      sk_v_r  <= 1'b0;
    end else if (sk_v_r) begin
      if (out_bus.ready) begin
        out_v_r <= 1'b1;
        sk_v_r  <= 1'b0;
      end
    end else if (slot_free) begin
      out_v_r <= push;
    end else if (push) begin
      sk_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (sk_v_r) begin
      if (out_bus.ready) begin
        out_temp_r <= sk_temp_r;
        out_st_r   <= sk_st_r;
      end
    end else if (slot_free) begin
      if (push) begin
        out_temp_r <= fin_temp;
        out_st_r   <= fin_st;
      end
    end else if (push) begin
      sk_temp_r <= fin_temp;
      sk_st_r   <= fin_st;
    end
  end

  assign out_bus.valid        = out_v_r;
  assign out_bus.temp_centi_c = out_temp_r;
  assign out_bus.conv_status  = out_st_r;

endmodule
